// ===== src/ggs_pkg.sv =====
// Shared constants, types and the arctangent table of the go-to-goal steering unit.
package ggs_pkg;

   // Fixed-point widths
   localparam int POS_W   = 16;   // Q8.8 positions
   localparam int DIFF_W  = 17;   // goal minus pose
   localparam int SQ_W    = 33;   // dx*dx + dy*dy
   localparam int DIST_W  = 17;   // floor sqrt of the above
   localparam int CMAG_W  = 33;   // magnitude of the cross product
   localparam int QUO_W   = 16;   // quotient bits of the asin argument
   localparam int Q14_W   = 16;   // Q1.14 values, range +-16384
   localparam int RSQ_W   = 29;   // 2^28 - r*r
   localparam int CX_W    = 34;   // CORDIC vector, units of 2^-30
   localparam int Z_W     = 28;   // CORDIC angle, units of 2^-24 rad
   localparam int ANG_W   = 16;   // Q3.13 angles
   localparam int GAIN_W  = 12;   // Q4.8 gains
   localparam int SPD_W   = 15;   // unsigned Q7.8 speeds
   localparam int CSR_A_W = 3;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TAB_LEN          = 24;
   localparam int PI_Q             = 25736;
   localparam int HALF_PI_Q        = 12868;
   localparam int TWO_PI_Q         = 51472;
   localparam int CORDIC_K30       = 652032874;
   localparam int ONE_Q14          = 16384;

   // Register indexes of the control port
   typedef enum logic [CSR_A_W-1:0] {
      REG_GOAL_X     = 3'd0,
      REG_GOAL_Y     = 3'd1,
      REG_TOLERANCE  = 3'd2,
      REG_SPD_GAIN   = 3'd3,
      REG_SPD_OFFSET = 3'd4,
      REG_SPD_LIMIT  = 3'd5,
      REG_GAIN_FIRST = 3'd6,
      REG_GAIN_OTHER = 3'd7
   } csr_idx_type;

   // Per-item context carried beside the arithmetic units
   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [ANG_W-1:0]  h;         // heading wrapped to +-pi
      logic signed [ANG_W-1:0]  zf;        // heading folded to +-pi/2
      logic                     hneg;      // fold flipped sin and cos
      logic [DIST_W-1:0]        distance;
      logic                     cross_neg;
      logic signed [Q14_W-1:0]  r;         // asin argument
   } ggs_ctx_type;

   // atan(2^-i) in units of 2^-24 rad
   function automatic logic [Z_W-1:0] atan_val(input int idx);
      logic [Z_W-1:0] v;
      case (idx)
         0:  v = 28'd13176795;
         1:  v = 28'd7778716;
         2:  v = 28'd4110060;
         3:  v = 28'd2086331;
         4:  v = 28'd1047214;
         5:  v = 28'd524117;
         6:  v = 28'd262123;
         7:  v = 28'd131069;
         8:  v = 28'd65536;
         9:  v = 28'd32768;
         10: v = 28'd16384;
         11: v = 28'd8192;
         12: v = 28'd4096;
         13: v = 28'd2048;
         14: v = 28'd1024;
         15: v = 28'd512;
         16: v = 28'd256;
         17: v = 28'd128;
         18: v = 28'd64;
         19: v = 28'd32;
         20: v = 28'd16;
         21: v = 28'd8;
         22: v = 28'd4;
         23: v = 28'd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/ggs_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module ggs_isqrt #(
   parameter int IN_W  = 33,
   parameter int TAG_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [IN_W-1:0]          in_val,
   input  logic [TAG_W-1:0]         in_tag,
   output logic                     out_valid,
   output logic [(IN_W+1)/2-1:0]    out_root,
   output logic [TAG_W-1:0]         out_tag
);
   localparam int OUT_W = (IN_W + 1) / 2;
   localparam int TW    = 2 * OUT_W + 1;

   logic [TW-1:0]    rem_ff  [OUT_W];
   logic [OUT_W-1:0] root_ff [OUT_W];
   logic [TAG_W-1:0] tag_ff  [OUT_W];
   logic             vld_ff  [OUT_W];

   for (genvar k = 0; k < OUT_W; k++) begin : g_stage
      localparam int B = OUT_W - 1 - k;
      logic [TW-1:0]    rem_cur, trial, rem_in;
      logic [OUT_W-1:0] root_cur, root_in;
      logic [TAG_W-1:0] tag_cur;
      logic             vld_cur;

      if (k == 0) begin : g_first
         assign rem_cur  = TW'(in_val);
         assign root_cur = '0;
         assign tag_cur  = in_tag;
         assign vld_cur  = in_valid;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign tag_cur  = tag_ff[k-1];
         assign vld_cur  = vld_ff[k-1];
      end

      // try bit B: (2*root + 2^B) * 2^B against the remainder
      always_comb begin
         trial   = (TW'(root_cur) << (B + 1)) + (TW'(1) << (2 * B));
         rem_in  = rem_cur;
         root_in = root_cur;
         if (rem_cur >= trial) begin
            rem_in  = rem_cur - trial;
            root_in = root_cur | (OUT_W'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_cur;
         end
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            tag_ff[k]  <= tag_cur;
         end
      end
   end

   assign out_valid = vld_ff[OUT_W-1];
   assign out_root  = root_ff[OUT_W-1];
   assign out_tag   = tag_ff[OUT_W-1];

endmodule

// ===== src/ggs_div.sv =====
// Pipelined restoring divider with an overflow stage, one quotient bit per stage.
module ggs_div #(
   parameter int N_W   = 33,
   parameter int D_W   = 17,
   parameter int Q_W   = 16,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  logic [N_W-1:0]   in_num,
   input  logic [D_W-1:0]   in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_quo,
   output logic             out_ovf,
   output logic [TAG_W-1:0] out_tag
);
   localparam int W  = ((N_W > D_W + Q_W) ? N_W : D_W + Q_W) + 1;
   localparam int NS = Q_W + 1;

   logic [W-1:0]     rem_ff [NS];
   logic [D_W-1:0]   den_ff [NS];
   logic [Q_W-1:0]   quo_ff [NS];
   logic             ovf_ff [NS];
   logic [TAG_W-1:0] tag_ff [NS];
   logic             vld_ff [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic [W-1:0]     rem_cur, shifted, rem_in;
      logic [D_W-1:0]   den_cur;
      logic [Q_W-1:0]   quo_cur, quo_in;
      logic             ovf_cur, ovf_in;
      logic [TAG_W-1:0] tag_cur;
      logic             vld_cur;

      if (k == 0) begin : g_first
         assign rem_cur = W'(in_num);
         assign den_cur = in_den;
         assign quo_cur = '0;
         assign ovf_cur = 1'b0;
         assign tag_cur = in_tag;
         assign vld_cur = in_valid;
         // quotient does not fit in Q_W bits
         always_comb begin
            shifted = W'(den_cur) << Q_W;
            rem_in  = rem_cur;
            quo_in  = quo_cur;
            ovf_in  = (rem_cur >= shifted);
         end
      end else begin : g_next
         localparam int B = Q_W - k;
         assign rem_cur = rem_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign quo_cur = quo_ff[k-1];
         assign ovf_cur = ovf_ff[k-1];
         assign tag_cur = tag_ff[k-1];
         assign vld_cur = vld_ff[k-1];
         // one restoring step for quotient bit B
         always_comb begin
            shifted = W'(den_cur) << B;
            rem_in  = rem_cur;
            quo_in  = quo_cur;
            ovf_in  = ovf_cur;
            if (rem_cur >= shifted) begin
               rem_in = rem_cur - shifted;
               quo_in = quo_cur | (Q_W'(1) << B);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_cur;
         end
         if (adv) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_cur;
            quo_ff[k] <= quo_in;
            ovf_ff[k] <= ovf_in;
            tag_ff[k] <= tag_cur;
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_quo   = quo_ff[NS-1];
   assign out_ovf   = ovf_ff[NS-1];
   assign out_tag   = tag_ff[NS-1];

endmodule

// ===== src/ggs_cordic.sv =====
// Pipelined CORDIC, rotation or vectoring mode, one micro-rotation per stage.
module ggs_cordic #(
   parameter int STEPS  = 16,
   parameter bit VECTOR = 1'b0,
   parameter int TAG_W  = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  logic signed [ggs_pkg::CX_W-1:0] in_x,
   input  logic signed [ggs_pkg::CX_W-1:0] in_y,
   input  logic signed [ggs_pkg::Z_W-1:0]  in_z,
   input  logic [TAG_W-1:0]                in_tag,
   output logic                            out_valid,
   output logic signed [ggs_pkg::CX_W-1:0] out_x,
   output logic signed [ggs_pkg::CX_W-1:0] out_y,
   output logic signed [ggs_pkg::Z_W-1:0]  out_z,
   output logic [TAG_W-1:0]                out_tag
);
   import ggs_pkg::*;

   localparam int N = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;

   logic signed [CX_W-1:0] x_ff   [N];
   logic signed [CX_W-1:0] y_ff   [N];
   logic signed [Z_W-1:0]  z_ff   [N];
   logic [TAG_W-1:0]       tag_ff [N];
   logic                   vld_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam logic signed [Z_W-1:0] ATAN = $signed(atan_val(i));
      logic signed [CX_W-1:0] x_cur, y_cur, x_in, y_in;
      logic signed [Z_W-1:0]  z_cur, z_in;
      logic [TAG_W-1:0]       tag_cur;
      logic                   vld_cur, ccw;

      if (i == 0) begin : g_first
         assign x_cur   = in_x;
         assign y_cur   = in_y;
         assign z_cur   = in_z;
         assign tag_cur = in_tag;
         assign vld_cur = in_valid;
      end else begin : g_next
         assign x_cur   = x_ff[i-1];
         assign y_cur   = y_ff[i-1];
         assign z_cur   = z_ff[i-1];
         assign tag_cur = tag_ff[i-1];
         assign vld_cur = vld_ff[i-1];
      end

      // direction: by angle sign when rotating, by y sign when vectoring
      always_comb begin
         ccw = VECTOR ? y_cur[CX_W-1] : !z_cur[Z_W-1];
         if (ccw) begin
            x_in = x_cur - (y_cur >>> i);
            y_in = y_cur + (x_cur >>> i);
            z_in = z_cur - ATAN;
         end else begin
            x_in = x_cur + (y_cur >>> i);
            y_in = y_cur - (x_cur >>> i);
            z_in = z_cur + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_cur;
         end
         if (adv) begin
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
            z_ff[i]   <= z_in;
            tag_ff[i] <= tag_cur;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_x     = x_ff[N-1];
   assign out_y     = y_ff[N-1];
   assign out_z     = z_ff[N-1];
   assign out_tag   = tag_ff[N-1];

endmodule

// ===== src/go_to_goal_steering_unit.sv =====
// Top level of the go-to-goal steering unit: stage registers, control registers, output register.
//
//   channel  | dir | fields (lowest bit first)
//   ---------+-----+-------------------------------------------------------
//   req_     | in  | pose_x[15:0], pose_y[31:16], pose_heading[47:32]
//   rsp_     | out | linear_cmd[15:0], angular_cmd[31:16], arrived[32]
//   csr_     | in  | write enable, register index 0..7, 16-bit data
//
// One pose per cycle while no result waits stalled in the output register. The pipeline depth
// is set by the two square roots, the divider and the two CORDIC units of N = min(CORDIC_STEPS, 24)
// micro-rotations, each one bit or one micro-rotation per stage.
// Synchronous reset clears the valid bits and loads the control registers with their defaults.
// The whole pipeline holds while a result waits in the output register.
module go_to_goal_steering_unit #(
   parameter int CORDIC_STEPS = ggs_pkg::CORDIC_STEPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [47:0]                    req_tdata,   // pose_x, pose_y, pose_heading
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [39:0]                    rsp_tdata,   // linear_cmd, angular_cmd, arrived, zeros
   input  logic                           csr_we,
   input  logic [ggs_pkg::CSR_A_W-1:0]    csr_addr,
   input  logic [15:0]                    csr_wdata
);
   import ggs_pkg::*;

   localparam int TAG_W = $bits(ggs_ctx_type);

   localparam logic signed [16:0]     PI_S      = 17'(PI_Q);
   localparam logic signed [16:0]     HALF_PI_S = 17'(HALF_PI_Q);
   localparam logic signed [16:0]     TWO_PI_S  = 17'(TWO_PI_Q);
   localparam logic signed [CX_W-1:0] K30_S     = CX_W'(CORDIC_K30);
   localparam logic signed [CX_W-1:0] HALF_LSB  = CX_W'(32768);
   localparam logic signed [CX_W-1:0] Q14_HI    = CX_W'(ONE_Q14);
   localparam logic signed [CX_W-1:0] Q14_LO    = -CX_W'(ONE_Q14);
   localparam logic signed [Z_W-1:0]  Z_RND     = Z_W'(1024);
   localparam logic signed [28:0]     ANG_RND   = 29'(4096);
   localparam logic signed [28:0]     SAT_HI    = 29'(32767);
   localparam logic signed [28:0]     SAT_LO    = -29'(32768);

   // rounds a CORDIC output to Q1.14 and clamps it to +-1
   function automatic logic signed [Q14_W-1:0] to_q14(input logic signed [CX_W-1:0] v);
      logic signed [CX_W-1:0] t;
      t = (v + HALF_LSB) >>> 16;
      if (t > Q14_HI) t = Q14_HI;
      if (t < Q14_LO) t = Q14_LO;
      return Q14_W'(t);
   endfunction

   // ---------------- control registers ----------------
   logic signed [POS_W-1:0] goal_x_ff, goal_y_ff;
   logic [SPD_W-1:0]        tol_ff, spd_off_ff, spd_lim_ff;
   logic [GAIN_W-1:0]       spd_gain_ff, gain_first_ff, gain_other_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff     <= '0;
         goal_y_ff     <= '0;
         tol_ff        <= SPD_W'(3);
         spd_gain_ff   <= GAIN_W'(512);
         spd_off_ff    <= SPD_W'(205);
         spd_lim_ff    <= SPD_W'(2048);
         gain_first_ff <= GAIN_W'(512);
         gain_other_ff <= GAIN_W'(2048);
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            REG_GOAL_X:     goal_x_ff     <= csr_wdata;
            REG_GOAL_Y:     goal_y_ff     <= csr_wdata;
            REG_TOLERANCE:  tol_ff        <= csr_wdata[SPD_W-1:0];
            REG_SPD_GAIN:   spd_gain_ff   <= csr_wdata[GAIN_W-1:0];
            REG_SPD_OFFSET: spd_off_ff    <= csr_wdata[SPD_W-1:0];
            REG_SPD_LIMIT:  spd_lim_ff    <= csr_wdata[SPD_W-1:0];
            REG_GAIN_FIRST: gain_first_ff <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_OTHER: gain_other_ff <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic rsp_tvalid_ff;
   logic adv;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 0: differences, heading wrap ----------------
   logic                     v0_ff;
   logic signed [DIFF_W-1:0] dx0_ff, dy0_ff, dx0_in, dy0_in;
   logic signed [ANG_W-1:0]  h0_ff, h0_in;
   logic signed [16:0]       hraw;

   always_comb begin
      dx0_in = $signed({goal_x_ff[15], goal_x_ff}) - $signed({req_tdata[15], req_tdata[15:0]});
      dy0_in = $signed({goal_y_ff[15], goal_y_ff})
             - $signed({req_tdata[31], req_tdata[31:16]});
      hraw   = $signed({req_tdata[47], req_tdata[47:32]});
      if (hraw > PI_S) begin
         hraw = hraw - TWO_PI_S;
      end else if (hraw < -PI_S) begin
         hraw = hraw + TWO_PI_S;
      end
      h0_in = ANG_W'(hraw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
      end
      if (adv) begin
         dx0_ff <= dx0_in;
         dy0_ff <= dy0_in;
         h0_ff  <= h0_in;
      end
   end

   // ---------------- stage 1: squares, heading fold ----------------
   logic        v1_ff;
   ggs_ctx_type ctx1_ff, ctx1_in;
   logic [31:0] sqx1_ff, sqy1_ff;
   logic signed [16:0] hf;

   always_comb begin
      hf      = $signed({h0_ff[15], h0_ff});
      ctx1_in = '0;
      ctx1_in.dx = dx0_ff;
      ctx1_in.dy = dy0_ff;
      ctx1_in.h  = h0_ff;
      if (hf > HALF_PI_S) begin
         hf = hf - PI_S;
         ctx1_in.hneg = 1'b1;
      end else if (hf < -HALF_PI_S) begin
         hf = hf + PI_S;
         ctx1_in.hneg = 1'b1;
      end
      ctx1_in.zf = ANG_W'(hf);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
      if (adv) begin
         ctx1_ff <= ctx1_in;
         sqx1_ff <= 32'(dx0_ff * dx0_ff);
         sqy1_ff <= 32'(dy0_ff * dy0_ff);
      end
   end

   // ---------------- stage 2: sum of squares ----------------
   logic            v2_ff;
   ggs_ctx_type     ctx2_ff;
   logic [SQ_W-1:0] sum2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         ctx2_ff <= ctx1_ff;
         sum2_ff <= SQ_W'(sqx1_ff) + SQ_W'(sqy1_ff);
      end
   end

   // ---------------- distance ----------------
   logic              va;
   logic [DIST_W-1:0] dist_a;
   logic [TAG_W-1:0]  tag_a;
   ggs_ctx_type       ctx_a;

   ggs_isqrt #(.IN_W(SQ_W), .TAG_W(TAG_W)) u_dist (
      .clock, .reset, .adv,
      .in_valid (v2_ff),
      .in_val   (sum2_ff),
      .in_tag   (TAG_W'(ctx2_ff)),
      .out_valid(va),
      .out_root (dist_a),
      .out_tag  (tag_a)
   );

   always_comb begin
      ctx_a          = ggs_ctx_type'(tag_a);
      ctx_a.distance = dist_a;
   end

   // ---------------- sin and cos ----------------
   logic                   vr;
   logic signed [CX_W-1:0] xr, yr;
   logic signed [Z_W-1:0]  zr_unused;
   logic [TAG_W-1:0]       tag_r;
   logic signed [Z_W-1:0]  z_start;

   assign z_start = $signed({{(Z_W-ANG_W){ctx_a.zf[ANG_W-1]}}, ctx_a.zf}) <<< 11;

   ggs_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0), .TAG_W(TAG_W)) u_sincos (
      .clock, .reset, .adv,
      .in_valid (va),
      .in_x     (K30_S),
      .in_y     ('0),
      .in_z     (z_start),
      .in_tag   (TAG_W'(ctx_a)),
      .out_valid(vr),
      .out_x    (xr),
      .out_y    (yr),
      .out_z    (zr_unused),
      .out_tag  (tag_r)
   );

   // ---------------- C1: round to Q1.14, undo fold ----------------
   logic                    vc1_ff;
   ggs_ctx_type             ctxc1_ff, ctx_r;
   logic signed [Q14_W-1:0] cos1_ff, sin1_ff, cos1_in, sin1_in;

   always_comb begin
      ctx_r   = ggs_ctx_type'(tag_r);
      cos1_in = to_q14(xr);
      sin1_in = to_q14(yr);
      if (ctx_r.hneg) begin
         cos1_in = -cos1_in;
         sin1_in = -sin1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc1_ff <= 1'b0;
      end else if (adv) begin
         vc1_ff <= vr;
      end
      if (adv) begin
         ctxc1_ff <= ctx_r;
         cos1_ff  <= cos1_in;
         sin1_ff  <= sin1_in;
      end
   end

   // ---------------- C2: cross product terms ----------------
   logic               vc2_ff;
   ggs_ctx_type        ctxc2_ff;
   logic signed [32:0] pc2_ff, ps2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc2_ff <= 1'b0;
      end else if (adv) begin
         vc2_ff <= vc1_ff;
      end
      if (adv) begin
         ctxc2_ff <= ctxc1_ff;
         pc2_ff   <= 33'($signed(cos1_ff) * $signed(ctxc1_ff.dy));
         ps2_ff   <= 33'($signed(sin1_ff) * $signed(ctxc1_ff.dx));
      end
   end

   // ---------------- C3: cross product, sign and magnitude ----------------
   logic               vc3_ff;
   ggs_ctx_type        ctxc3_ff, ctxc3_in;
   logic [CMAG_W-1:0]  cmag3_ff, cmag3_in;
   logic signed [33:0] xprod;

   always_comb begin
      xprod    = 34'(pc2_ff) - 34'(ps2_ff);
      ctxc3_in = ctxc2_ff;
      ctxc3_in.cross_neg = xprod[33];
      cmag3_in = xprod[33] ? CMAG_W'(-xprod) : CMAG_W'(xprod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc3_ff <= 1'b0;
      end else if (adv) begin
         vc3_ff <= vc2_ff;
      end
      if (adv) begin
         ctxc3_ff <= ctxc3_in;
         cmag3_ff <= cmag3_in;
      end
   end

   // ---------------- asin argument: |cross| / distance ----------------
   logic             vd, ovf_d;
   logic [QUO_W-1:0] quo_d;
   logic [TAG_W-1:0] tag_d;

   ggs_div #(.N_W(CMAG_W), .D_W(DIST_W), .Q_W(QUO_W), .TAG_W(TAG_W)) u_div (
      .clock, .reset, .adv,
      .in_valid (vc3_ff),
      .in_num   (cmag3_ff),
      .in_den   (ctxc3_ff.distance),
      .in_tag   (TAG_W'(ctxc3_ff)),
      .out_valid(vd),
      .out_quo  (quo_d),
      .out_ovf  (ovf_d),
      .out_tag  (tag_d)
   );

   // ---------------- R1: clamp and sign ----------------
   logic             vr1_ff;
   ggs_ctx_type      ctxr1_ff, ctxr1_in;
   logic [QUO_W-1:0] mag;

   always_comb begin
      ctxr1_in = ggs_ctx_type'(tag_d);
      mag = (ovf_d || quo_d > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14) : quo_d;
      if (ctxr1_in.distance == '0) begin
         ctxr1_in.r = '0;
      end else begin
         ctxr1_in.r = ctxr1_in.cross_neg ? -$signed(mag) : $signed(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vr1_ff <= 1'b0;
      end else if (adv) begin
         vr1_ff <= vd;
      end
      if (adv) begin
         ctxr1_ff <= ctxr1_in;
      end
   end

   // ---------------- R2: r squared ----------------
   logic             vr2_ff;
   ggs_ctx_type      ctxr2_ff;
   logic [RSQ_W-1:0] rsq2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vr2_ff <= 1'b0;
      end else if (adv) begin
         vr2_ff <= vr1_ff;
      end
      if (adv) begin
         ctxr2_ff <= ctxr1_ff;
         rsq2_ff  <= RSQ_W'(ctxr1_ff.r * ctxr1_ff.r);
      end
   end

   // ---------------- sqrt(1 - r^2) ----------------
   logic                  vb;
   logic [(RSQ_W+1)/2-1:0] cosr_b;
   logic [TAG_W-1:0]      tag_b;
   ggs_ctx_type           ctx_b;

   ggs_isqrt #(.IN_W(RSQ_W), .TAG_W(TAG_W)) u_cosr (
      .clock, .reset, .adv,
      .in_valid (vr2_ff),
      .in_val   ((RSQ_W'(1) << 28) - rsq2_ff),
      .in_tag   (TAG_W'(ctxr2_ff)),
      .out_valid(vb),
      .out_root (cosr_b),
      .out_tag  (tag_b)
   );

   // ---------------- asin by vectoring ----------------
   logic                   vv;
   logic signed [CX_W-1:0] xv_start, yv_start, xv_unused, yv_unused;
   logic signed [Z_W-1:0]  zv;
   logic [TAG_W-1:0]       tag_v;

   always_comb begin
      ctx_b    = ggs_ctx_type'(tag_b);
      xv_start = CX_W'(cosr_b) <<< 16;
      yv_start = $signed({{(CX_W-Q14_W){ctx_b.r[Q14_W-1]}}, ctx_b.r}) <<< 16;
   end

   ggs_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1), .TAG_W(TAG_W)) u_asin (
      .clock, .reset, .adv,
      .in_valid (vb),
      .in_x     (xv_start),
      .in_y     (yv_start),
      .in_z     ('0),
      .in_tag   (tag_b),
      .out_valid(vv),
      .out_x    (xv_unused),
      .out_y    (yv_unused),
      .out_z    (zv),
      .out_tag  (tag_v)
   );

   // ---------------- F0: heading error, drive direction, gain, arrival, speed product ----------------
   logic                    vf0_ff, fwd_f0_ff, fwd_f0_in, arr_f0_ff;
   logic signed [ANG_W-1:0] dal_f0_ff;
   logic [GAIN_W-1:0]       gain_f0_ff, gain_f0_in;
   logic [28:0]             sprod_f0_ff;
   ggs_ctx_type             ctx_v;
   logic signed [Z_W-1:0]   zround;
   logic                    cos_t, sin_t, dx_ge, dx_le, dy_ge, dy_le;

   always_comb begin
      ctx_v  = ggs_ctx_type'(tag_v);
      zround = (zv + Z_RND) >>> 11;
      cos_t  = (ctx_v.h != '0) && (ctx_v.h > -ANG_W'(HALF_PI_Q))
            && (ctx_v.h < ANG_W'(HALF_PI_Q));
      sin_t  = (ctx_v.h > ANG_W'(0)) && (ctx_v.h < ANG_W'(PI_Q))
            && (ctx_v.h != ANG_W'(HALF_PI_Q));
      dx_ge  = !ctx_v.dx[DIFF_W-1];
      dy_ge  = !ctx_v.dy[DIFF_W-1];
      dx_le  = ctx_v.dx[DIFF_W-1] || (ctx_v.dx == '0);
      dy_le  = ctx_v.dy[DIFF_W-1] || (ctx_v.dy == '0);
      gain_f0_in = gain_other_ff;
      if (cos_t && sin_t) begin
         fwd_f0_in = dx_ge && dy_ge;
         if (fwd_f0_in) gain_f0_in = gain_first_ff;
      end else if (cos_t) begin
         fwd_f0_in = dx_ge && dy_le;
      end else if (sin_t) begin
         fwd_f0_in = dx_le && dy_ge;
      end else begin
         fwd_f0_in = dx_le && dy_le;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf0_ff <= 1'b0;
      end else if (adv) begin
         vf0_ff <= vv;
      end
      if (adv) begin
         dal_f0_ff   <= ANG_W'(zround);
         fwd_f0_ff   <= fwd_f0_in;
         gain_f0_ff  <= gain_f0_in;
         arr_f0_ff   <= (ctx_v.distance < DIST_W'(tol_ff));
         sprod_f0_ff <= 29'(spd_gain_ff) * 29'(ctx_v.distance);
      end
   end

   // ---------------- F1: steering product, clamped speed ----------------
   logic               vf1_ff, fwd_f1_ff, arr_f1_ff;
   logic signed [28:0] angp_f1_ff;
   logic [SPD_W-1:0]   speed_f1_ff, speed_f1_in;
   logic [21:0]        spd_sum;

   always_comb begin
      spd_sum     = 22'(sprod_f0_ff >> 8) + 22'(spd_off_ff);
      speed_f1_in = (spd_sum > 22'(spd_lim_ff)) ? spd_lim_ff : spd_sum[SPD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf1_ff <= 1'b0;
      end else if (adv) begin
         vf1_ff <= vf0_ff;
      end
      if (adv) begin
         angp_f1_ff  <= 29'($signed({1'b0, gain_f0_ff}) * dal_f0_ff);
         speed_f1_ff <= speed_f1_in;
         fwd_f1_ff   <= fwd_f0_ff;
         arr_f1_ff   <= arr_f0_ff;
      end
   end

   // ---------------- output register: round, saturate, direction, arrival ----------------
   logic signed [15:0] lin_ff, lin_in, ang_ff, ang_in;
   logic               arr_ff;
   logic signed [28:0] ang_t;

   always_comb begin
      ang_t = (angp_f1_ff + ANG_RND) >>> 13;
      if (ang_t > SAT_HI) ang_t = SAT_HI;
      if (ang_t < SAT_LO) ang_t = SAT_LO;
      if (!fwd_f1_ff) begin
         ang_t = -ang_t;
         if (ang_t > SAT_HI) ang_t = SAT_HI;
      end
      ang_in = 16'(ang_t);
      lin_in = fwd_f1_ff ? $signed({1'b0, speed_f1_ff}) : -$signed({1'b0, speed_f1_ff});
      if (arr_f1_ff) begin
         ang_in = '0;
         lin_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= vf1_ff;
      end
      if (adv) begin
         lin_ff <= lin_in;
         ang_ff <= ang_in;
         arr_ff <= arr_f1_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, arr_ff, ang_ff, lin_ff};

endmodule

// ===== src/ggs_checker.sv =====
// Port-level checks of the go-to-goal steering unit, bound to the top level.
module ggs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // input side moves exactly when the output register can take an item
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready out of step with output stall");

   // arrived items carry zero commands and zero padding
   a_arrived: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[31:0] == 32'd0 && rsp_tdata[39:33] == 7'd0)
      else $error("arrived item with non-zero command");

   // nothing comes out straight after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind go_to_goal_steering_unit ggs_checker u_ggs_checker (.*);

// ===== tb/sv/tb_go_to_goal_steering_unit.sv =====
// Testbench of the go-to-goal steering unit: directed and random poses against a bit-exact predictor.
module tb_go_to_goal_steering_unit;
   import ggs_pkg::*;

   localparam int LATENCY = 100;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [15:0] lin;
      logic signed [15:0] ang;
      logic               arrived;
   } steer_cmd_type;

   // Mismatch reporting
   int n_errors = 0;
   task automatic report(input string msg);
      $display("MISMATCH: %s", msg);
      n_errors++;
   endtask

   // Register copy and predictor
   longint goal_x = 0, goal_y = 0, tol = 3, spd_gain = 512, spd_off = 205;
   longint spd_lim = 2048, gain_first = 512, gain_other = 2048;

   function automatic longint shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint r = 0, b = 64'sh1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint atan_of(int i);
      return longint'(atan_val(i));
   endfunction

   function automatic longint round_q14(longint v);
      longint q = shr(v + (64'sd1 << 15), 16);
      if (q > ONE_Q14) q = ONE_Q14;
      if (q < -ONE_Q14) q = -ONE_Q14;
      return q;
   endfunction

   function automatic longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic int n_steps();
      return (CORDIC_STEPS_DEF > TAB_LEN) ? TAB_LEN : CORDIC_STEPS_DEF;
   endfunction

   function automatic void heading_sin_cos(longint h, output longint c, output longint s);
      bit flip = 0;
      longint x = CORDIC_K30, y = 0, z, nx;
      if (h > HALF_PI_Q) begin
         h = h - PI_Q; flip = 1;
      end else if (h < -HALF_PI_Q) begin
         h = h + PI_Q; flip = 1;
      end
      z = h * 2048;
      for (int i = 0; i < n_steps(); i++) begin
         if (z >= 0) begin
            nx = x - shr(y, i); y = y + shr(x, i); z = z - atan_of(i);
         end else begin
            nx = x + shr(y, i); y = y - shr(x, i); z = z + atan_of(i);
         end
         x = nx;
      end
      c = round_q14(x);
      s = round_q14(y);
      if (flip) begin
         c = -c; s = -s;
      end
   endfunction

   function automatic longint arcsine(longint r);
      longint x = int_sqrt((64'sd1 << 28) - r * r) * 65536;
      longint y = r * 65536, z = 0, nx;
      for (int i = 0; i < n_steps(); i++) begin
         if (y >= 0) begin
            nx = x + shr(y, i); y = y - shr(x, i); z = z + atan_of(i);
         end else begin
            nx = x - shr(y, i); y = y + shr(x, i); z = z - atan_of(i);
         end
         x = nx;
      end
      return shr(z + 1024, 11);
   endfunction

   function automatic steer_cmd_type predict_cmd(logic [47:0] pose);
      steer_cmd_type o;
      longint dx, dy, h, distance, c, s, xprod, r, mag, da, gain, spd, ang;
      bit cos_t, sin_t, fwd;
      dx = goal_x - longint'($signed(pose[15:0]));
      dy = goal_y - longint'($signed(pose[31:16]));
      h = longint'($signed(pose[47:32]));
      distance = int_sqrt(dx * dx + dy * dy);
      o.lin = 0; o.ang = 0; o.arrived = 0;
      if (distance < tol) begin
         o.arrived = 1;
         return o;
      end
      if (h > PI_Q) h = h - TWO_PI_Q;
      else if (h < -PI_Q) h = h + TWO_PI_Q;
      heading_sin_cos(h, c, s);
      xprod = c * dy - s * dx;
      r = 0;
      if (distance != 0) begin
         mag = (xprod < 0 ? -xprod : xprod) / distance;
         if (mag > ONE_Q14) mag = ONE_Q14;
         r = xprod < 0 ? -mag : mag;
      end
      da = arcsine(r);
      cos_t = h != 0 && h > -HALF_PI_Q && h < HALF_PI_Q;
      sin_t = h > 0 && h < PI_Q && h != HALF_PI_Q;
      gain = gain_other;
      if (cos_t && sin_t) begin
         fwd = dx >= 0 && dy >= 0;
         if (fwd) gain = gain_first;
      end else if (cos_t) fwd = dx >= 0 && dy <= 0;
      else if (sin_t) fwd = dx <= 0 && dy >= 0;
      else fwd = dx <= 0 && dy <= 0;
      spd = ((spd_gain * distance) >> 8) + spd_off;
      if (spd > spd_lim) spd = spd_lim;
      ang = sat16(shr(gain * da + 4096, 13));
      if (!fwd) ang = sat16(-ang);
      o.lin = 16'(sat16(fwd ? spd : -spd));
      o.ang = 16'(ang);
      return o;
   endfunction

   // Scoreboard: expected commands in order of acceptance
   class steer_scoreboard;
      steer_cmd_type pending[$];
      function void note_pose(logic [47:0] pose);
         pending.push_back(predict_cmd(pose));
      endfunction
      task check_cmd(logic [39:0] d);
         steer_cmd_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected command %h", d));
            return;
         end
         e = pending.pop_front();
         if (d[15:0] !== e.lin)
            report($sformatf("linear_cmd %0d, want %0d", $signed(d[15:0]), e.lin));
         if (d[31:16] !== e.ang)
            report($sformatf("angular_cmd %0d, want %0d", $signed(d[31:16]), e.ang));
         if (d[32] !== e.arrived)
            report($sformatf("arrived %b, want %b", d[32], e.arrived));
      endtask
   endclass

   steer_scoreboard sb = new();

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0, csr_we = 0;
   logic req_tready, rsp_tvalid;
   logic [47:0] req_tdata = '0;
   logic [39:0] rsp_tdata;
   logic [CSR_A_W-1:0] csr_addr = '0;
   logic [15:0] csr_wdata = '0;
   bit idle_free = 0;
   longint cycles = 0;

   go_to_goal_steering_unit dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Sample results at the rising edge; cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) sb.check_cmd(rsp_tdata);
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_go_to_goal_steering_unit: errors");
         $finish;
      end
   end

   // Receiver stalls in bursts
   always @(negedge clock) begin
      if (idle_free || $urandom_range(0, 3) != 0) rsp_tready <= 1;
      else begin
         rsp_tready <= 0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
   end

   task automatic write_reg(csr_idx_type idx, longint val);
      csr_we <= 1; csr_addr <= idx; csr_wdata <= 16'(val);
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         REG_GOAL_X: goal_x = longint'($signed(16'(val)));
         REG_GOAL_Y: goal_y = longint'($signed(16'(val)));
         REG_TOLERANCE: tol = val & 16'h7FFF;
         REG_SPD_GAIN: spd_gain = val & 12'hFFF;
         REG_SPD_OFFSET: spd_off = val & 16'h7FFF;
         REG_SPD_LIMIT: spd_lim = val & 16'h7FFF;
         REG_GAIN_FIRST: gain_first = val & 12'hFFF;
         default: gain_other = val & 12'hFFF;
      endcase
   endtask

   // Send one pose, holding valid until accepted
   task automatic send_pose(longint px, longint py, longint hd);
      if (!idle_free && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {16'(hd), 16'(py), 16'(px)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_pose(req_tdata);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   function automatic longint rnd_heading();
      case ($urandom_range(0, 5))
         0: return longint'($signed(16'($urandom)));
         1: return HALF_PI_Q * $urandom_range(0, 4) - PI_Q;
         default: return longint'($urandom_range(0, 2 * PI_Q)) - PI_Q;
      endcase
   endfunction

   // Pose near the goal mostly, so tolerance and quadrants are exercised
   task automatic random_pose();
      longint px, py;
      if ($urandom_range(0, 2) == 0) begin
         px = longint'($signed(16'($urandom)));
         py = longint'($signed(16'($urandom)));
      end else begin
         px = sat16(goal_x + longint'($urandom_range(0, 2000)) - 1000);
         py = sat16(goal_y + longint'($urandom_range(0, 2000)) - 1000);
      end
      send_pose(px, py, rnd_heading());
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // Directed: extremes, quadrant edges, arrival, wrap
      send_pose(0, 0, 0);
      send_pose(2, 0, 0);
      send_pose(32767, 32767, 32767);
      send_pose(-32768, -32768, -32768);
      send_pose(-32768, 32767, PI_Q);
      send_pose(32767, -32768, -PI_Q);
      send_pose(-500, -500, HALF_PI_Q);
      send_pose(500, -500, -HALF_PI_Q);
      send_pose(-500, 500, 6000);
      send_pose(500, 500, -6000);
      send_pose(-500, 0, 20000);
      send_pose(0, 500, -20000);
      send_pose(300, -400, 25737);
      send_pose(-300, 400, -25737);
      drain();
      // Register extremes, zero tolerance, zero distance
      write_reg(REG_TOLERANCE, 0);
      write_reg(REG_GAIN_FIRST, 4095);
      write_reg(REG_GAIN_OTHER, 4095);
      write_reg(REG_SPD_GAIN, 4095);
      write_reg(REG_SPD_OFFSET, 32767);
      write_reg(REG_SPD_LIMIT, 32767);
      write_reg(REG_GOAL_X, -32768);
      write_reg(REG_GOAL_Y, 32767);
      send_pose(-32768, 32767, 1000);
      send_pose(32767, -32768, 1000);
      send_pose(-32000, 32000, -1000);
      send_pose(0, 0, 12000);
      drain();
      // Random phases with varied settings
      for (int ph = 0; ph < 7; ph++) begin
         write_reg(REG_GOAL_X, ph == 0 ? 32767 : $urandom);
         write_reg(REG_GOAL_Y, ph == 0 ? -32768 : $urandom);
         write_reg(REG_TOLERANCE, ph == 1 ? 32767 : $urandom_range(0, 600));
         write_reg(REG_SPD_GAIN, ph == 2 ? 0 : $urandom_range(0, 4095));
         write_reg(REG_SPD_OFFSET, ph == 2 ? 0 : $urandom_range(0, 32767));
         write_reg(REG_SPD_LIMIT, ph == 2 ? 0 : $urandom_range(0, 32767));
         write_reg(REG_GAIN_FIRST, ph == 3 ? 0 : $urandom_range(0, 4095));
         write_reg(REG_GAIN_OTHER, ph == 3 ? 0 : $urandom_range(0, 4095));
         if (ph == 6) idle_free = 1;
         repeat (200) random_pose();
         drain();
      end
      if (n_errors == 0) $display("tb_go_to_goal_steering_unit: clean");
      else $display("tb_go_to_goal_steering_unit: errors");
      $finish;
   end
endmodule

// ===== files.f =====
src/ggs_pkg.sv
src/ggs_isqrt.sv
src/ggs_div.sv
src/ggs_cordic.sv
src/go_to_goal_steering_unit.sv
src/ggs_checker.sv
tb/sv/tb_go_to_goal_steering_unit.sv
